>>> hdl/fixed_frame_header_tail_deframer_macros.svh
// Assertion macros for the fixed-frame deframer.
// Included by the RTL files that carry assertions; needs clk and rst_n in scope.
`ifndef FIXED_FRAME_HEADER_TAIL_DEFRAMER_MACROS_SVH
`define FIXED_FRAME_HEADER_TAIL_DEFRAMER_MACROS_SVH

// Checked only while out of reset
`define FFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define FFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/ffd_pkg.sv
// Shared types and constants for the fixed-frame deframer.
// No dependencies; imported by ffd_step and the top level.
package ffd_pkg;

  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 32;
  localparam int FRAME_LEN_W     = 11;
  localparam int IDX_W           = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int HDR_BYTES       = 4;
  localparam int MIN_FRAME_BYTES = 8;
  localparam int LEN_RESET       = 64;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_HUNT    = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_TAIL    = 3'd3,
    KIND_GOOD    = 3'd4,
    KIND_BAD     = 3'd5
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_LENGTH = 2'd2
  } cfg_idx_t;

  // Hunting window and frame flags
  typedef struct packed {
    logic [WORD_W-1:0] window;
    logic [2:0]        fill;
    logic              in_frame;
    logic              tail_match;
  } hunt_state_t;

endpackage

>>> hdl/ffd_step.sv
// Next-state and result logic for one received byte.
// Depends on ffd_pkg; purely combinational, driven from the top-level registers.
module ffd_step #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  ffd_pkg::hunt_state_t                       state_i,
  input  logic [$clog2(MAX_FRAME_BYTES)-1:0]         pos_i,
  input  logic [$clog2(MAX_FRAME_BYTES+1)-1:0]       len_i,
  input  logic [ffd_pkg::WORD_W-1:0]                 header_word,
  input  logic [ffd_pkg::WORD_W-1:0]                 tail_word,
  input  logic [ffd_pkg::BYTE_W-1:0]                 rx_byte,
  output ffd_pkg::hunt_state_t                       state_o,
  output logic [$clog2(MAX_FRAME_BYTES)-1:0]         pos_o,
  output ffd_pkg::kind_t                             kind_o,
  output logic [ffd_pkg::IDX_W-1:0]                  idx_o
);
  import ffd_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = ((LEN_W > FRAME_LEN_W) ? LEN_W : FRAME_LEN_W) + 1;

  logic [WORD_W-1:0] win_shift;
  logic [2:0]        fill_inc;
  logic [CMP_W-1:0]  p_ext;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  slot_full;
  logic              is_payload;
  logic              is_last;
  logic [1:0]        slot;
  logic [BYTE_W-1:0] want;
  logic              tm_nxt;

  // Sliding window, newest byte enters at the top
  assign win_shift = {rx_byte, state_i.window[WORD_W-1:BYTE_W]};
  assign fill_inc  = (state_i.fill < 3'(HDR_BYTES)) ? state_i.fill + 3'd1 : state_i.fill;

  // Position against the effective frame length
  assign p_ext      = CMP_W'(pos_i);
  assign len_ext    = CMP_W'(len_i);
  assign is_payload = (p_ext + CMP_W'(HDR_BYTES)) < len_ext;
  assign is_last    = (p_ext + CMP_W'(1)) >= len_ext;
  assign slot_full  = p_ext + CMP_W'(HDR_BYTES) - len_ext;
  assign slot       = is_last ? 2'd3 : slot_full[1:0];
  assign want       = tail_word[slot*BYTE_W +: BYTE_W];
  assign tm_nxt     = state_i.tail_match && (rx_byte == want);

  always_comb begin
    state_o = state_i;
    pos_o   = pos_i;
    kind_o  = KIND_HUNT;
    idx_o   = '0;
    if (!state_i.in_frame) begin
      // hunting for the header
      state_o.window = win_shift;
      state_o.fill   = fill_inc;
      if ((fill_inc >= 3'(HDR_BYTES)) && (win_shift == header_word)) begin
        kind_o             = KIND_HEADER;
        idx_o              = IDX_W'(HDR_BYTES - 1);
        state_o.in_frame   = 1'b1;
        state_o.tail_match = 1'b1;
        pos_o              = POS_W'(HDR_BYTES);
      end
    end else begin
      idx_o = p_ext[IDX_W-1:0];
      if (is_payload) begin
        kind_o = KIND_PAYLOAD;
        pos_o  = pos_i + POS_W'(1);
      end else if (is_last) begin
        // frame ends: judge the tail, then hunt again with an empty window
        kind_o             = tm_nxt ? KIND_GOOD : KIND_BAD;
        state_o.window     = '0;
        state_o.fill       = 3'd0;
        state_o.in_frame   = 1'b0;
        state_o.tail_match = 1'b1;
        pos_o              = '0;
      end else begin
        kind_o             = KIND_TAIL;
        state_o.tail_match = tm_nxt;
        pos_o              = pos_i + POS_W'(1);
      end
    end
  end

endmodule

>>> hdl/fixed_frame_header_tail_deframer.sv
// Each accepted byte's result word is registered and shows on the out_ port in the next cycle.
// Throughput: one byte per cycle; the result register frees as it is taken, so
// in_ready only drops while a result waits and out_ready is low.
// Reset (rst_n low, synchronous): hunting, empty window, no result pending,
// header and tail words zero, frame length 64 (clamped to MAX_FRAME_BYTES).
module fixed_frame_header_tail_deframer #(
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffd_pkg::WORD_W-1:0]         cfg_data,
  // received bytes
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ffd_pkg::BYTE_W-1:0]         in_rx_byte,
  // classified bytes
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffd_pkg::BYTE_W-1:0]         out_data_byte,
  output logic [2:0]                         out_kind,
  output logic [ffd_pkg::IDX_W-1:0]          out_byte_index
);
  import ffd_pkg::*;
  `include "fixed_frame_header_tail_deframer_macros.svh"

  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = ((LEN_W > FRAME_LEN_W) ? LEN_W : FRAME_LEN_W) + 1;
  localparam int LEN_INIT = (LEN_RESET > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : LEN_RESET;

  logic [WORD_W-1:0] header_r;
  logic [WORD_W-1:0] tail_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  len_nxt;
  logic [CMP_W-1:0]  len_req;

  hunt_state_t       hunt_r;
  hunt_state_t       hunt_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  kind_t             step_kind;
  logic [IDX_W-1:0]  step_idx;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [2:0]        out_kind_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              in_fire;

  // Configuration: always ready, length clamped once at write time
  assign cfg_ready = 1'b1;
  assign len_req   = CMP_W'(cfg_data[FRAME_LEN_W-1:0]);

  always_comb begin
    if (len_req < CMP_W'(MIN_FRAME_BYTES)) begin
      len_nxt = LEN_W'(MIN_FRAME_BYTES);
    end else if (len_req > CMP_W'(MAX_FRAME_BYTES)) begin
      len_nxt = LEN_W'(MAX_FRAME_BYTES);
    end else begin
      len_nxt = len_req[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      tail_r   <= '0;
      len_r    <= LEN_W'(LEN_INIT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER: header_r <= cfg_data;
        CFG_TAIL:   tail_r   <= cfg_data;
        CFG_LENGTH: len_r    <= len_nxt;
        default: ;
      endcase
    end
  end

  // Byte classification
  ffd_step #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_step (
    .state_i     (hunt_r),
    .pos_i       (pos_r),
    .len_i       (len_r),
    .header_word (header_r),
    .tail_word   (tail_r),
    .rx_byte     (in_rx_byte),
    .state_o     (hunt_nxt),
    .pos_o       (pos_nxt),
    .kind_o      (step_kind),
    .idx_o       (step_idx)
  );

  // Input side takes a byte whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r.window     <= '0;
      hunt_r.fill       <= 3'd0;
      hunt_r.in_frame   <= 1'b0;
      hunt_r.tail_match <= 1'b1;
      pos_r             <= '0;
    end else if (in_fire) begin
      hunt_r <= hunt_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte_r <= in_rx_byte;
      out_kind_r <= step_kind;
      out_idx_r  <= step_idx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_byte_r;
  assign out_kind       = out_kind_r;
  assign out_byte_index = out_idx_r;

  // Checks
  `FFD_ASSERT(a_pos_in_frame, hunt_r.in_frame |-> (pos_r >= POS_W'(HDR_BYTES)) && (CMP_W'(pos_r) < CMP_W'(MAX_FRAME_BYTES)), "frame position out of range")
  `FFD_ASSERT(a_hunt_clean, !hunt_r.in_frame |-> (pos_r == '0) && hunt_r.tail_match, "hunting with stale frame state")
  `FFD_ASSERT(a_header_index, out_valid_r && (out_kind_r == KIND_HEADER) |-> out_idx_r == IDX_W'(HDR_BYTES - 1), "header result with wrong index")
  `FFD_ASSERT(a_end_hunts, in_fire && (step_kind == KIND_GOOD || step_kind == KIND_BAD) |=> !hunt_r.in_frame && (hunt_r.fill == 3'd0), "frame end did not restart hunting")
  `FFD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !hunt_r.in_frame, "reset left a result or frame pending")

endmodule
